// ===== design/vkt_pkg.sv =====
`default_nettype none
package vkt_pkg;
  localparam int unsigned TableSlotsDef = 16;
  localparam int unsigned KeyW = 32;
  localparam int unsigned RelW = 16;
  localparam int unsigned InfoW = 32;
  localparam int unsigned OrdW = 5;

  typedef enum logic [2:0] {
    CmdAdd     = 3'd0,
    CmdFind    = 3'd1,
    CmdFindAll = 3'd2,
    CmdDelOne  = 3'd3,
    CmdDelAll  = 3'd4,
    CmdShow    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StNone  = 2'd2,
    StEmpty = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the incoming item, restart the scan
    logic step;      // examine the current slot and advance
    logic emit_slot; // register the current slot as an entry result
    logic emit_add;  // register the add result (write slot)
    logic emit_stat; // register the final status result
    logic clear;     // invalidate the current slot
    logic [1:0] status;
  } vkt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] command;
    logic key_hit;   // current slot valid and key equal
    logic rel_hit;   // current slot release equal to the requested one
    logic slot_vld;  // current slot valid
    logic scan_end;  // current slot is the last one
    logic free_seen; // a free slot was found
    logic any_hit;   // at least one entry emitted/matched
  } vkt_stat_t;
endpackage
`default_nettype wire

// ===== design/vkt_datapath.sv =====
`default_nettype none
module vkt_datapath import vkt_pkg::*; #(
  parameter int unsigned TableSlots = TableSlotsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire vkt_cmd_t             cmd_i,
  output vkt_stat_t                 stat_o,
  input  wire logic [2:0]           in_command_i,
  input  wire logic [KeyW-1:0]      in_key_i,
  input  wire logic [RelW-1:0]      in_rel_i,
  input  wire logic [InfoW-1:0]     in_info_i,
  output logic [1:0]                res_status_o,
  output logic                      res_has_o,
  output logic [KeyW-1:0]           res_key_o,
  output logic [RelW-1:0]           res_rel_o,
  output logic [InfoW-1:0]          res_info_o,
  output logic [OrdW-1:0]           res_ord_o,
  output logic                      res_last_o
);
  localparam int unsigned IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1;

  logic [TableSlots-1:0] valid_q;
  logic [KeyW-1:0]  key_mem  [TableSlots];
  logic [RelW-1:0]  rel_mem  [TableSlots];
  logic [InfoW-1:0] info_mem [TableSlots];

  logic [2:0]       cmd_q;
  logic [KeyW-1:0]  key_q;
  logic [RelW-1:0]  rel_q;
  logic [InfoW-1:0] info_q;
  logic [IdxW-1:0]  idx_q, free_q;
  logic             free_seen_q, seen_q, any_q;
  logic [RelW-1:0]  top_q;
  logic [OrdW-1:0]  ord_q;

  logic [KeyW-1:0]  cur_key;
  logic [RelW-1:0]  cur_rel;
  logic [InfoW-1:0] cur_info;
  logic             cur_vld, key_hit;
  logic [RelW-1:0]  new_rel;

  assign cur_vld  = valid_q[idx_q];
  assign cur_key  = key_mem[idx_q];
  assign cur_rel  = rel_mem[idx_q];
  assign cur_info = info_mem[idx_q];
  assign key_hit  = cur_vld && (cur_key == key_q);
  assign new_rel  = !seen_q ? '0 : ((&top_q) ? top_q : top_q + 1'b1);

  assign stat_o.command   = cmd_q;
  assign stat_o.key_hit   = key_hit;
  assign stat_o.rel_hit   = cur_rel == rel_q;
  assign stat_o.slot_vld  = cur_vld;
  assign stat_o.scan_end  = idx_q == IdxW'(TableSlots - 1);
  assign stat_o.free_seen = free_seen_q;
  assign stat_o.any_hit   = any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.emit_add) begin
      valid_q[free_q] <= 1'b1;
    end else if (cmd_i.clear) begin
      valid_q[idx_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_add) begin
      key_mem[free_q]  <= key_q;
      rel_mem[free_q]  <= new_rel;
      info_mem[free_q] <= info_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q       <= in_command_i;
      key_q       <= in_key_i;
      rel_q       <= in_rel_i;
      info_q      <= in_info_i;
      idx_q       <= '0;
      free_seen_q <= 1'b0;
      seen_q      <= 1'b0;
      any_q       <= 1'b0;
      top_q       <= '0;
      ord_q       <= '0;
    end else if (cmd_i.step) begin
      if (!cur_vld && !free_seen_q) begin
        free_q      <= idx_q;
        free_seen_q <= 1'b1;
      end
      if (key_hit && (!seen_q || cur_rel > top_q)) begin
        top_q  <= cur_rel;
        seen_q <= 1'b1;
      end
      if (cmd_i.emit_slot || cmd_i.clear) any_q <= 1'b1;
      if (cmd_i.emit_slot) ord_q <= ord_q + 1'b1;
      if (!stat_o.scan_end) idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_slot) begin
      res_status_o <= StOk;
      res_has_o    <= 1'b1;
      res_key_o    <= cur_key;
      res_rel_o    <= cur_rel;
      res_info_o   <= cur_info;
      res_ord_o    <= (cmd_q == CmdShow) ? ord_q + 1'b1 : '0;
      res_last_o   <= 1'b0;
    end else if (cmd_i.emit_add) begin
      res_status_o <= StOk;
      res_has_o    <= 1'b1;
      res_key_o    <= key_q;
      res_rel_o    <= new_rel;
      res_info_o   <= info_q;
      res_ord_o    <= '0;
      res_last_o   <= 1'b1;
    end else if (cmd_i.emit_stat) begin
      res_status_o <= cmd_i.status;
      res_has_o    <= 1'b0;
      res_key_o    <= '0;
      res_rel_o    <= '0;
      res_info_o   <= '0;
      res_ord_o    <= '0;
      res_last_o   <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== design/vkt_ctrl.sv =====
`default_nettype none
module vkt_ctrl import vkt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire vkt_stat_t stat_i,
  output vkt_cmd_t       cmd_o
);
  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SScan = 4'b0010,
    SOut  = 4'b0100,
    SFin  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   hit, emit;

  // output register free this cycle
  logic oreg_free;
  assign oreg_free = !ov_q || out_ready_i;

  always_comb begin
    hit = 1'b0;
    case (stat_i.command) inside
      CmdFind, CmdDelOne: hit = stat_i.key_hit && stat_i.rel_hit;
      CmdFindAll, CmdDelAll: hit = stat_i.key_hit;
      CmdShow: hit = stat_i.slot_vld;
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    ov_d       = ov_q && !out_ready_i;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SScan;
        end
      end
      SScan: begin
        if (oreg_free) begin
          cmd_o.step = 1'b1;
          emit = hit && stat_i.command != CmdDelOne;
          cmd_o.emit_slot = emit;
          cmd_o.clear = hit && (stat_i.command == CmdDelOne ||
                                stat_i.command == CmdDelAll);
          if (emit) ov_d = 1'b1;
          // find and delete one stop at the first match
          if ((hit && (stat_i.command == CmdFind || stat_i.command == CmdDelOne))
              || stat_i.scan_end) begin
            state_d = SFin;
          end
        end
      end
      SFin: begin
        if (oreg_free) begin
          ov_d = 1'b1;
          state_d = SOut;
          case (stat_i.command) inside
            CmdAdd: begin
              if (stat_i.free_seen) cmd_o.emit_add = 1'b1;
              else begin
                cmd_o.emit_stat = 1'b1;
                cmd_o.status = StFull;
              end
            end
            CmdFind, CmdFindAll, CmdDelAll, CmdShow: begin
              cmd_o.emit_stat = 1'b1;
              if (!stat_i.any_hit) begin
                cmd_o.status = (stat_i.command == CmdShow) ? StEmpty : StNone;
              end
            end
            CmdDelOne: begin
              cmd_o.emit_stat = 1'b1;
              if (!stat_i.any_hit) cmd_o.status = StNone;
            end
            default: cmd_o.emit_stat = 1'b1;
          endcase
        end
      end
      SOut: begin
        if (out_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end
endmodule
`default_nettype wire

// ===== design/versioned_key_table.sv =====
// A command scans its slots one per cycle while the output register is free
// (find and delete one stop at a match), then registers the final result. A
// new command is taken only once the last result is accepted; entry results
// leave the output register as fast as the sink takes them (one slot per cycle).
// Reset: asynchronous, active low; clears all slot valid bits and control.
`default_nettype none
module versioned_key_table import vkt_pkg::*; #(
  parameter int unsigned TableSlots = TableSlotsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [2:0] command, [34:3] key, [50:35] release_req, [82:51] info
  input  wire logic [87:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [1:0] status, [2] has_entry, [34:3] entry_key, [50:35] entry_release,
  // [82:51] entry_info, [87:83] ordinal
  output logic [87:0]       m_axis_tdata,
  output logic              m_axis_tlast
);
  vkt_cmd_t  cmd;
  vkt_stat_t stat;
  logic [1:0]       r_st;
  logic             r_has;
  logic [KeyW-1:0]  r_key;
  logic [RelW-1:0]  r_rel;
  logic [InfoW-1:0] r_info;
  logic [OrdW-1:0]  r_ord;

  vkt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(stat), .cmd_o(cmd)
  );

  vkt_datapath #(.TableSlots(TableSlots)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .in_command_i(s_axis_tdata[2:0]), .in_key_i(s_axis_tdata[34:3]),
    .in_rel_i(s_axis_tdata[50:35]), .in_info_i(s_axis_tdata[82:51]),
    .res_status_o(r_st), .res_has_o(r_has), .res_key_o(r_key),
    .res_rel_o(r_rel), .res_info_o(r_info), .res_ord_o(r_ord),
    .res_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {r_ord, r_info, r_rel, r_key, r_has, r_st};

`ifndef NO_ASSERTIONS
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("input taken with pending result");
  a_entry_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2] && !m_axis_tlast) |-> m_axis_tdata[1:0] == StOk)
    else $error("entry result with bad status");
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.emit_slot, cmd.emit_add, cmd.emit_stat}) <= 1)
    else $error("multiple result loads");
`endif
endmodule
`default_nettype wire

// ===== tb/versioned_key_table_tb.sv =====
`default_nettype none
module versioned_key_table_tb;
  import vkt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = TableSlotsDef;
  localparam int unsigned IdleLimit = 20000;
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  typedef struct packed {
    logic [1:0]       status;
    logic             has_entry;
    logic [KeyW-1:0]  key;
    logic [RelW-1:0]  rel;
    logic [InfoW-1:0] info;
    logic [OrdW-1:0]  ordinal;
    logic             last;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic m_axis_tlast;

  versioned_key_table u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // shadow copy of the table
  logic             sh_valid [Slots];
  logic [KeyW-1:0]  sh_key [Slots];
  logic [RelW-1:0]  sh_rel [Slots];
  logic [InfoW-1:0] sh_info [Slots];

  table_result_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_sink = 1'b0;
  bit stall_sink = 1'b1;

  function automatic table_result_t status_item(logic [1:0] st);
    table_result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic table_result_t slot_item(int s, logic [OrdW-1:0] ord);
    table_result_t r;
    r = '0;
    r.has_entry = 1'b1;
    r.key = sh_key[s];
    r.rel = sh_rel[s];
    r.info = sh_info[s];
    r.ordinal = ord;
    return r;
  endfunction

  // work out the results of one command and update the shadow table
  task automatic predict_command(logic [2:0] cmd, logic [KeyW-1:0] key,
                                 logic [RelW-1:0] rel, logic [InfoW-1:0] info);
    int free_slot;
    bit seen;
    bit done;
    logic [RelW-1:0] top;
    int n;
    table_result_t r;
    free_slot = -1;
    seen = 1'b0;
    done = 1'b0;
    top = '0;
    n = 0;
    case (cmd)
      CmdAdd: begin
        for (int s = 0; s < Slots; s++) begin
          if (sh_valid[s]) begin
            if (sh_key[s] == key && (!seen || sh_rel[s] > top)) begin
              top = sh_rel[s];
              seen = 1'b1;
            end
          end else if (free_slot < 0) begin
            free_slot = s;
          end
        end
        if (free_slot < 0) begin
          pending_results.push_back(status_item(StFull));
        end else begin
          sh_valid[free_slot] = 1'b1;
          sh_key[free_slot] = key;
          sh_rel[free_slot] = !seen ? '0 : (top == '1 ? top : top + 1'b1);
          sh_info[free_slot] = info;
          r = slot_item(free_slot, '0);
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      CmdFind, CmdDelOne: begin
        for (int s = 0; s < Slots && !done; s++) begin
          if (sh_valid[s] && sh_key[s] == key && sh_rel[s] == rel) begin
            if (cmd == CmdFind) pending_results.push_back(slot_item(s, '0));
            else sh_valid[s] = 1'b0;
            pending_results.push_back(status_item(StOk));
            done = 1'b1;
          end
        end
        if (!done) pending_results.push_back(status_item(StNone));
      end
      CmdFindAll, CmdDelAll: begin
        for (int s = 0; s < Slots; s++) begin
          if (sh_valid[s] && sh_key[s] == key) begin
            pending_results.push_back(slot_item(s, '0));
            if (cmd == CmdDelAll) sh_valid[s] = 1'b0;
            n++;
          end
        end
        pending_results.push_back(status_item(n > 0 ? StOk : StNone));
      end
      CmdShow: begin
        for (int s = 0; s < Slots; s++) begin
          if (sh_valid[s]) begin
            n++;
            pending_results.push_back(slot_item(s, OrdW'(n)));
          end
        end
        pending_results.push_back(status_item(n > 0 ? StOk : StEmpty));
      end
      default: pending_results.push_back(status_item(StOk));
    endcase
  endtask

  // hold valid after the accept; the next send replaces the item, an idle stretch drops valid
  task automatic send_command(logic [2:0] cmd, logic [KeyW-1:0] key,
                              logic [RelW-1:0] rel, logic [InfoW-1:0] info);
    s_axis_tdata <= {5'b0, info, rel, key, cmd};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_command(cmd, key, rel, info);
    @(negedge clk_i);
  endtask

  // random gap between items, often none so bursts form
  task automatic sender_gap();
    if ($urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (Slots + 4) @(negedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] pick_key(logic [KeyW-1:0] pool[$]);
    if ($urandom_range(9) == 0 || pool.size() == 0) return $urandom;
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  task automatic test_directed();
    send_command(CmdShow, 32'h0, 16'h0, 32'h0);
    send_command(CmdFind, 32'h8000_0000, 16'hFFFF, 32'h0);
    send_command(CmdDelAll, 32'h7FFF_FFFF, 16'h0, 32'h0);
    send_command(CmdAdd, 32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(CmdAdd, 32'h8000_0000, 16'h0, 32'h0);
    send_command(CmdAdd, 32'h7FFF_FFFF, 16'hAAAA, 32'h5555_5555);
    send_command(CmdFind, 32'h8000_0000, 16'h1, 32'h0);
    send_command(CmdFindAll, 32'h8000_0000, 16'h0, 32'h0);
    send_command(CmdDelOne, 32'h8000_0000, 16'h0, 32'h0);
    send_command(CmdDelOne, 32'h8000_0000, 16'h0, 32'h0);
    send_command(CmdAdd, 32'h8000_0000, 16'h0, 32'h1234_5678);
    send_command(CmdShow, 32'h0, 16'h0, 32'h0);
    send_command(CmdSpare6, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(CmdSpare7, 32'h0, 16'h0, 32'h0);
    send_command(CmdDelAll, 32'h8000_0000, 16'h0, 32'h0);
    send_command(CmdFindAll, 32'h1, 16'h0, 32'h0);
    wait_drained();
  endtask

  // fill the table past full, then drain with delete all
  task automatic test_overflow();
    for (int i = 0; i < Slots + 2; i++) begin
      send_command(CmdAdd, 32'h0000_0042, 16'h0, $urandom);
    end
    send_command(CmdShow, 32'h0, 16'h0, 32'h0);
    send_command(CmdDelAll, 32'h0000_0042, 16'h0, 32'h0);
    wait_drained();
  endtask

  // walk a release number up through repeated adds of one key
  task automatic test_release_ceiling();
    send_command(CmdAdd, 32'hDEAD_BEEF, 16'h0, 32'h1);
    for (int i = 0; i < 3; i++) begin
      send_command(CmdAdd, 32'hDEAD_BEEF, 16'h0, $urandom);
    end
    send_command(CmdFindAll, 32'hDEAD_BEEF, 16'h0, 32'h0);
    send_command(CmdDelAll, 32'hDEAD_BEEF, 16'h0, 32'h0);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_backpressure();
    hold_sink = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_command(i % 2 ? CmdShow : CmdAdd, 32'h0000_0077, 16'h0, $urandom);
    end
    hold_sink = 1'b0;
    send_command(CmdDelAll, 32'h0000_0077, 16'h0, 32'h0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [KeyW-1:0] pool[$];
    logic [2:0] cmd;
    logic [KeyW-1:0] key;
    logic [RelW-1:0] rel;
    for (int i = 0; i < 6; i++) pool.push_back($urandom);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: cmd = CmdAdd;
        7, 8: cmd = CmdFind;
        9, 10: cmd = CmdFindAll;
        11, 12, 13: cmd = CmdDelOne;
        14, 15: cmd = CmdDelAll;
        16, 17: cmd = CmdShow;
        18: cmd = CmdSpare6;
        default: cmd = CmdSpare7;
      endcase
      key = pick_key(pool);
      rel = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4));
      send_command(cmd, key, rel, $urandom);
      sender_gap();
      if (i % 90 == 89) wait_drained();
    end
    wait_drained();
  endtask

  // receiver stall pattern: alternating runs of random lengths, always ready and randomly not ready
  initial begin
    int run_len;
    @(posedge rst_ni);
    forever begin
      run_len = $urandom_range(1, stall_sink ? 6 : 20);
      repeat (run_len) begin
        @(negedge clk_i);
        m_axis_tready <= !hold_sink && (!stall_sink || $urandom_range(2) != 0);
      end
      stall_sink = !stall_sink;
    end
  end

  // long hold-off, counted here while the sender pushes
  initial begin
    @(posedge hold_sink);
    repeat (400) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    table_result_t got;
    table_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[34:3],
             m_axis_tdata[50:35], m_axis_tdata[82:51], m_axis_tdata[87:83],
             m_axis_tlast};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: st %0d/%0d has %0b/%0b key %h/%h rel %h/%h",
                     want.status, got.status, want.has_entry, got.has_entry,
                     want.key, got.key, want.rel, got.rel);
            $display("  info %h/%h ord %0d/%0d last %0b/%0b", want.info, got.info,
                     want.ordinal, got.ordinal, want.last, got.last);
          end
        end
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int s = 0; s < Slots; s++) sh_valid[s] = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_overflow();
    test_release_ceiling();
    test_backpressure();
    test_random(220);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/vkt_pkg.sv
design/vkt_datapath.sv
design/vkt_ctrl.sv
design/versioned_key_table.sv
tb/versioned_key_table_tb.sv
